@@ hw/rtl/mpsd_pkg.sv @@
package mpsd_pkg;

  // Command codes carried on in_tuser
  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_TEXT    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  localparam int CMD_W   = 2;
  localparam int SLOT_W  = 4;
  localparam int CPOS_W  = 5;
  localparam int SYM_W   = 8;
  localparam int ACT_W   = 5;
  localparam int TPOS_W  = 16;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  localparam logic [ACT_W-1:0]  ACT_RESET = 5'd16;
  localparam logic [TPOS_W-1:0] TPOS_MAX  = 16'hFFFF;

  // Operation broadcast from the sequencer to every cell
  typedef struct packed {
    logic              load;
    logic              text;
    logic              restart;
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic [CPOS_W-1:0] cpos;
    logic [SYM_W-1:0]  sym;
    logic              last;
    logic [ACT_W-1:0]  act;
  } op_t;

endpackage

@@ hw/rtl/mpsd_ram.sv @@
module mpsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/mpsd_cell.sv @@
module mpsd_cell #(
  parameter int IDX     = 0,
  parameter int MAX_LEN = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  mpsd_pkg::op_t op,
  input  logic          hit_in,
  output logic          hit_out
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW = $clog2(MAX_LEN + 1);

  logic [LW-1:0]              len_r, len_nxt;
  logic [LW-1:0]              prog_r, prog_nxt;
  logic [mpsd_pkg::SYM_W-1:0] chr;
  logic                       sel;
  logic                       active;
  logic                       step;
  logic                       done;

  // Slot hit by a load inside the table
  assign sel = (32'(op.slot) == IDX) && (32'(op.cpos) < MAX_LEN);
  assign active = (IDX < 32'(op.act));

  mpsd_ram #(
    .WIDTH (mpsd_pkg::SYM_W),
    .DEPTH (MAX_LEN)
  ) u_ram (
    .clk   (clk),
    .we    (op.load && sel),
    .waddr (AW'(op.cpos)),
    .wdata (op.sym),
    .raddr (prog_r[AW-1:0]),
    .rdata (chr)
  );

  // Advance on the expected character while unfinished
  assign step = op.text && !op.found && active && (len_r != '0) && (prog_r < len_r)
                && (chr == op.sym);
  assign done = step && ((prog_r + LW'(1)) == len_r);
  assign hit_out = hit_in | done;

  always_comb begin
    len_nxt  = len_r;
    prog_nxt = prog_r;
    if (op.load && sel) begin
      prog_nxt = '0;
      if (op.last) begin
        len_nxt = LW'(32'(op.cpos) + 1);
      end
    end else if (op.restart) begin
      prog_nxt = '0;
    end else if (step) begin
      prog_nxt = prog_r + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      prog_r <= '0;
    end else begin
      len_r  <= len_nxt;
      prog_r <= prog_nxt;
    end
  end

endmodule

@@ hw/rtl/multi_pattern_subsequence_detector_core.sv @@
// Multi-pattern subsequence detector.
//
// Input stream (in_*): one beat per command. in_tuser carries the command
// (load pattern character, text character, restart). in_tdata carries the
// pattern slot, the character position and the symbol; in_tlast marks the
// final character of a pattern on a load.
// Result stream (out_*): one beat per text character only, giving the sticky
// found flag, the 1-based position of the first completion and found_now.
// Configuration (cfg_*): cfg_we writes the number of active pattern slots.
//
// Every beat is first captured, while each cell reads its next expected
// character from its character RAM at the current progress, and then
// executed in all cells at once. A new beat is taken only after the pending
// one has executed, because of the registered read of the per-cell RAM. A
// text result appears on out_* in the cycle after its execute cycle.
// At reset the slots are empty, progress and position are cleared and all
// sixteen slots are active; character RAM content stays undefined until
// loaded. When the receiver stalls, the result register holds; one more beat
// is captured, and a text beat then waits for the result register to free
// up while a load or restart beat goes ahead.
module multi_pattern_subsequence_detector_core #(
  parameter int NUM_PATTERNS = 16,
  parameter int MAX_LEN      = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [3:0] pattern_index, [8:4] char_position, [16:9] symbol, rest zero
  input  logic [mpsd_pkg::IN_TDATA_W-1:0]       in_tdata,
  // [1:0] command
  input  logic [mpsd_pkg::CMD_W-1:0]            in_tuser,
  input  logic                                  in_tlast,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [0] found, [16:1] match_position, [17] found_now, rest zero
  output logic [mpsd_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  logic                                  cfg_we,
  input  logic [mpsd_pkg::ACT_W-1:0]            cfg_wdata
);

  // Captured beat waiting for its execute cycle
  logic                                pend_r, pend_nxt;
  logic [mpsd_pkg::CMD_W-1:0]          cmd_r;
  logic [mpsd_pkg::SLOT_W-1:0]         slot_r;
  logic [mpsd_pkg::CPOS_W-1:0]         cpos_r;
  logic [mpsd_pkg::SYM_W-1:0]          sym_r;
  logic                                last_r;

  logic [mpsd_pkg::ACT_W-1:0]          act_r;
  logic [mpsd_pkg::TPOS_W-1:0]         cnt_r, cnt_nxt;
  logic                                found_r, found_nxt;
  logic [mpsd_pkg::TPOS_W-1:0]         mpos_r, mpos_nxt;

  logic                                oval_r, oval_nxt;
  logic                                ofound_r;
  logic [mpsd_pkg::TPOS_W-1:0]         opos_r;
  logic                                onow_r;

  logic                                exec;
  logic                                in_fire;
  logic                                now;
  mpsd_pkg::op_t                       op;
  logic [NUM_PATTERNS:0]               hit;

  assign in_tready = !pend_r;
  assign in_fire   = in_tvalid && in_tready;

  // Execute a pending beat; a text beat waits until the result register can take it
  assign exec = pend_r && ((cmd_r != mpsd_pkg::CMD_TEXT) || !oval_r || out_tready);

  always_comb begin
    op.load    = exec && (cmd_r == mpsd_pkg::CMD_LOAD);
    op.text    = exec && (cmd_r == mpsd_pkg::CMD_TEXT);
    op.restart = exec && (cmd_r == mpsd_pkg::CMD_RESTART);
    op.found   = found_r;
    op.slot    = slot_r;
    op.cpos    = cpos_r;
    op.sym     = sym_r;
    op.last    = last_r;
    op.act     = act_r;
  end

  // Completion ripples down the row of cells
  assign hit[0] = 1'b0;

  for (genvar i = 0; i < NUM_PATTERNS; i++) begin : g_cell
    mpsd_cell #(
      .IDX     (i),
      .MAX_LEN (MAX_LEN)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .op      (op),
      .hit_in  (hit[i]),
      .hit_out (hit[i+1])
    );
  end

  assign now = hit[NUM_PATTERNS];

  always_comb begin
    pend_nxt  = pend_r;
    cnt_nxt   = cnt_r;
    found_nxt = found_r;
    mpos_nxt  = mpos_r;
    oval_nxt  = oval_r && !out_tready;
    if (exec) begin
      pend_nxt = 1'b0;
    end
    if (in_fire) begin
      pend_nxt = 1'b1;
    end
    if (op.restart) begin
      cnt_nxt   = '0;
      found_nxt = 1'b0;
      mpos_nxt  = '0;
    end else if (op.text) begin
      // Saturate the text position
      if (cnt_r != mpsd_pkg::TPOS_MAX) begin
        cnt_nxt = cnt_r + 16'd1;
      end
      if (!found_r && now) begin
        found_nxt = 1'b1;
        mpos_nxt  = cnt_nxt;
      end
      oval_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 1'b0;
      act_r   <= mpsd_pkg::ACT_RESET;
      cnt_r   <= '0;
      found_r <= 1'b0;
      mpos_r  <= '0;
      oval_r  <= 1'b0;
    end else begin
      pend_r  <= pend_nxt;
      cnt_r   <= cnt_nxt;
      found_r <= found_nxt;
      mpos_r  <= mpos_nxt;
      oval_r  <= oval_nxt;
      if (cfg_we) begin
        act_r <= cfg_wdata;
      end
    end
  end

  // Payload registers: capture on accept, load result on text execute
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= in_tuser;
      slot_r <= in_tdata[3:0];
      cpos_r <= in_tdata[8:4];
      sym_r  <= in_tdata[16:9];
      last_r <= in_tlast;
    end
    if (op.text) begin
      ofound_r <= found_nxt;
      opos_r   <= mpos_nxt;
      onow_r   <= !found_r && now;
    end
  end

  assign out_tvalid = oval_r;
  assign out_tdata  = {6'd0, onow_r, opos_r, ofound_r};

endmodule

@@ hw/rtl/mpsd_checker.sv @@
module mpsd_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [mpsd_pkg::OUT_TDATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // A taken beat occupies the block for its execute cycle
  a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input beat taken on consecutive cycles");

  a_now_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[17] |-> out_tdata[0] && (out_tdata[16:1] != 16'd0))
    else $error("found_now without found position");

  a_nofound_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> (out_tdata[16:1] == 16'd0) && !out_tdata[17])
    else $error("position set without found");

endmodule

bind multi_pattern_subsequence_detector_core mpsd_checker u_mpsd_checker (.*);

@@ tb/sv/tb_top.sv @@
module tb_top;

  localparam int CMD_W       = mpsd_pkg::CMD_W;
  localparam int SLOT_W      = mpsd_pkg::SLOT_W;
  localparam int CPOS_W      = mpsd_pkg::CPOS_W;
  localparam int SYM_W       = mpsd_pkg::SYM_W;
  localparam int ACT_W       = mpsd_pkg::ACT_W;
  localparam int TPOS_W      = mpsd_pkg::TPOS_W;
  localparam int IN_TDATA_W  = mpsd_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = mpsd_pkg::OUT_TDATA_W;

  localparam int NUM_SLOTS    = 16;
  localparam int SLOT_LEN     = 32;
  localparam int RAND_BEATS   = 1000;
  // Covers the capture and execute steps and the result register, with margin.
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 1000000;

  // Command code that the block has to ignore.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Expected result of one text beat.
  typedef struct packed {
    logic              found;
    logic [TPOS_W-1:0] pos;
    logic              found_now;
  } match_rpt_t;

  logic                    clk;
  logic                    rst_n     = 1'b0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  // [3:0] pattern_index, [8:4] char_position, [16:9] symbol, rest zero
  logic [IN_TDATA_W-1:0]   in_tdata  = '0;
  // [1:0] command
  logic [CMD_W-1:0]        in_tuser  = mpsd_pkg::CMD_TEXT;
  logic                    in_tlast  = 1'b0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  // [0] found, [16:1] match_position, [17] found_now, rest zero
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic                    cfg_we    = 1'b0;
  logic [ACT_W-1:0]        cfg_wdata = mpsd_pkg::ACT_RESET;

  // Shadow of the block's matching state, updated at each accepted beat.
  logic [SYM_W-1:0]  pat_char    [NUM_SLOTS][SLOT_LEN];
  bit                pat_written [NUM_SLOTS][SLOT_LEN] = '{default: '0};
  logic [5:0]        pat_len     [NUM_SLOTS] = '{default: '0};
  logic [5:0]        prog        [NUM_SLOTS] = '{default: '0};
  logic [TPOS_W-1:0] text_pos    = '0;
  logic              hit_flag    = 1'b0;
  logic [TPOS_W-1:0] hit_pos     = '0;
  logic [ACT_W-1:0]  act_slots   = mpsd_pkg::ACT_RESET;

  match_rpt_t expected_q[$];

  int mismatches   = 0;
  int beat_count   = 0;
  int cycle_count  = 0;
  int snd_idle_pct = 16;
  int rcv_idle_pct = 74;

  multi_pattern_subsequence_detector_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Apply one accepted beat to the shadow state; queue the result a text
  // beat produces. Load and restart beats produce nothing, nor does the
  // unused command.
  function automatic void predict_beat(input logic [CMD_W-1:0] cmd,
                                       input logic [SLOT_W-1:0] slot,
                                       input logic [CPOS_W-1:0] cpos,
                                       input logic [SYM_W-1:0] sym,
                                       input logic last);
    int         n;
    logic       hit_now;
    match_rpt_t rpt;
    case (cmd)
      mpsd_pkg::CMD_LOAD: begin
        pat_char[slot][cpos] = sym;
        pat_written[slot][cpos] = 1'b1;
        if (last) pat_len[slot] = 6'(cpos) + 6'd1;
        prog[slot] = '0;
      end
      mpsd_pkg::CMD_RESTART: begin
        prog = '{default: '0};
        text_pos = '0;
        hit_flag = 1'b0;
        hit_pos = '0;
      end
      mpsd_pkg::CMD_TEXT: begin
        // Saturate the text position at its top value.
        if (text_pos != mpsd_pkg::TPOS_MAX) text_pos++;
        hit_now = 1'b0;
        if (!hit_flag) begin
          // Counts above the slot total act as the total; zero freezes all.
          n = (act_slots > NUM_SLOTS) ? NUM_SLOTS : int'(act_slots);
          for (int i = 0; i < n; i++) begin
            if (pat_len[i] != 0 && prog[i] < pat_len[i] &&
                pat_char[i][prog[i]] == sym) begin
              prog[i]++;
              if (prog[i] == pat_len[i]) hit_now = 1'b1;
            end
          end
          if (hit_now) begin
            hit_flag = 1'b1;
            hit_pos = text_pos;
          end
        end
        rpt.found = hit_flag;
        rpt.pos = hit_pos;
        rpt.found_now = hit_now;
        expected_q.push_back(rpt);
      end
      default: ;
    endcase
  endfunction

  // Drive one beat, optionally after a random idle gap, and hold it until
  // the block takes it. tvalid stays high on return so back-to-back beats
  // never drop it.
  task automatic send_beat(input logic [CMD_W-1:0] cmd,
                           input logic [SLOT_W-1:0] slot,
                           input logic [CPOS_W-1:0] cpos,
                           input logic [SYM_W-1:0] sym,
                           input logic last);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(IN_TDATA_W - SYM_W - CPOS_W - SLOT_W){1'b0}}, sym, cpos, slot};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    predict_beat(cmd, slot, cpos, sym, last);
    if (cmd != CMD_UNUSED) beat_count++;
  endtask

  // Send a beat of the given command with random filler in the other fields.
  task automatic send_filler(input logic [CMD_W-1:0] cmd);
    send_beat(cmd, SLOT_W'($urandom), CPOS_W'($urandom), SYM_W'($urandom),
              1'($urandom));
  endtask

  // Send a text beat with random filler around the symbol.
  task automatic send_text(input logic [SYM_W-1:0] sym);
    send_beat(mpsd_pkg::CMD_TEXT, SLOT_W'($urandom), CPOS_W'($urandom), sym,
              1'($urandom));
  endtask

  // Drop tvalid, wait for every queued result, then let the pipeline drain
  // beats that produce no result.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the active slot count; only done with the block idle.
  task automatic set_active_slots(input logic [ACT_W-1:0] count);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we    <= 1'b0;
    act_slots = count;
  endtask

  // Field extremes, the ignored command, found behavior, restart and the
  // progress clear that any load of a slot causes.
  task automatic test_directed_cases();
    send_beat(mpsd_pkg::CMD_TEXT,    4'd0, 5'd0,  8'h00, 1'b0); // nothing loaded yet
    send_beat(CMD_UNUSED,            4'hF, 5'h1F, 8'hFF, 1'b1); // must be ignored
    send_beat(mpsd_pkg::CMD_LOAD,    4'd3, 5'd31, 8'hC3, 1'b0); // length stays zero
    send_beat(mpsd_pkg::CMD_TEXT,    4'd0, 5'd0,  8'hC3, 1'b0); // empty slot, no match
    send_beat(mpsd_pkg::CMD_LOAD,    4'hF, 5'd0,  8'hFF, 1'b1);
    send_beat(mpsd_pkg::CMD_LOAD,    4'd0, 5'd0,  8'h00, 1'b0);
    send_beat(mpsd_pkg::CMD_LOAD,    4'd0, 5'd1,  8'h5A, 1'b1);
    send_beat(mpsd_pkg::CMD_TEXT,    4'd0, 5'd0,  8'h00, 1'b0);
    send_beat(mpsd_pkg::CMD_TEXT,    4'd0, 5'd0,  8'h33, 1'b0);
    send_beat(mpsd_pkg::CMD_TEXT,    4'd0, 5'd0,  8'h5A, 1'b0); // slot 0 completes
    send_beat(mpsd_pkg::CMD_TEXT,    4'hF, 5'h1F, 8'hFF, 1'b1); // found is sticky
    send_beat(mpsd_pkg::CMD_RESTART, 4'hF, 5'h1F, 8'hFF, 1'b1);
    send_beat(mpsd_pkg::CMD_TEXT,    4'd0, 5'd0,  8'hFF, 1'b0); // slot 15 at position 1
    send_beat(mpsd_pkg::CMD_RESTART, 4'd0, 5'd0,  8'h00, 1'b0);
    send_beat(mpsd_pkg::CMD_TEXT,    4'd0, 5'd0,  8'h00, 1'b0);
    send_beat(mpsd_pkg::CMD_LOAD,    4'd0, 5'd0,  8'h00, 1'b0); // clears slot 0 progress
    send_beat(mpsd_pkg::CMD_TEXT,    4'd0, 5'd0,  8'h5A, 1'b0);
    send_beat(mpsd_pkg::CMD_TEXT,    4'd0, 5'd0,  8'h00, 1'b0);
    send_beat(mpsd_pkg::CMD_TEXT,    4'd0, 5'd0,  8'h5A, 1'b0);
    send_beat(mpsd_pkg::CMD_RESTART, 4'd0, 5'd0,  8'h00, 1'b0);
    send_beat(mpsd_pkg::CMD_LOAD,    4'd0, 5'd1,  8'hA5, 1'b0); // length kept at two
    send_beat(mpsd_pkg::CMD_TEXT,    4'd0, 5'd0,  8'h00, 1'b0);
    send_beat(mpsd_pkg::CMD_TEXT,    4'd0, 5'd0,  8'hA5, 1'b0);
  endtask

  // Active count at zero, one, full, above full and in between; slots
  // outside the active range keep their progress frozen.
  task automatic test_active_slot_count();
    logic [ACT_W-1:0] counts [6];
    counts = '{5'd0, 5'd1, 5'd16, 5'd17, 5'd31, 5'd8};
    counts[5] = ACT_W'($urandom_range(2, 15));
    // One single-character pattern per slot, distinct characters.
    for (int i = 0; i < NUM_SLOTS; i++)
      send_beat(mpsd_pkg::CMD_LOAD, SLOT_W'(i), 5'd0, SYM_W'(8'h10 + i), 1'b1);
    foreach (counts[k]) begin
      set_active_slots(counts[k]);
      send_filler(mpsd_pkg::CMD_RESTART);
      send_text(8'h1F);
      send_filler(mpsd_pkg::CMD_RESTART);
      send_text(8'h10);
      send_filler(mpsd_pkg::CMD_RESTART);
      send_text(SYM_W'(8'h10 + $urandom_range(15)));
    end
    // Advance slot 1 halfway, shrink the active range, then grow it again.
    send_beat(mpsd_pkg::CMD_LOAD, 4'd1, 5'd0, 8'hAA, 1'b0);
    send_beat(mpsd_pkg::CMD_LOAD, 4'd1, 5'd1, 8'hBB, 1'b1);
    set_active_slots(5'd16);
    send_filler(mpsd_pkg::CMD_RESTART);
    send_beat(mpsd_pkg::CMD_TEXT, 4'd0, 5'd0, 8'hAA, 1'b0);
    set_active_slots(5'd1);
    send_beat(mpsd_pkg::CMD_TEXT, 4'd0, 5'd0, 8'hBB, 1'b0);
    set_active_slots(5'd16);
    send_beat(mpsd_pkg::CMD_TEXT, 4'd0, 5'd0, 8'hBB, 1'b0);
  endtask

  // One episode: maybe a new active count, usually a restart, a few fresh
  // patterns over a small alphabet, then text drawn mostly from it so that
  // completions are common, mixed with stray loads and ignored commands.
  task automatic run_episode();
    logic [SYM_W-1:0]  alpha [4];
    logic [SLOT_W-1:0] slot;
    logic [CPOS_W-1:0] cpos;
    logic              last;
    logic [SYM_W-1:0]  sym;
    int                len;
    foreach (alpha[k]) alpha[k] = SYM_W'($urandom_range(255));
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(7))
        0:       set_active_slots(5'd0);
        1:       set_active_slots(5'd1);
        2:       set_active_slots(5'd31);
        3:       set_active_slots(ACT_W'($urandom_range(17, 31)));
        default: set_active_slots(ACT_W'($urandom_range(2, 16)));
      endcase
    end
    if ($urandom_range(9) < 7)
      send_filler(mpsd_pkg::CMD_RESTART);
    repeat ($urandom_range(3)) begin
      slot = SLOT_W'($urandom_range(NUM_SLOTS - 1));
      // Mostly short patterns, now and then up to the full slot.
      len = ($urandom_range(15) == 0) ? int'($urandom_range(6, SLOT_LEN))
                                      : int'($urandom_range(1, 5));
      for (int p = 0; p < len; p++)
        send_beat(mpsd_pkg::CMD_LOAD, slot, CPOS_W'(p), alpha[$urandom_range(3)],
                  p == len - 1);
    end
    repeat ($urandom_range(5, 30)) begin
      case ($urandom_range(39))
        0, 1: begin
          // Stray load: close the pattern only if every earlier character
          // of the slot has been written.
          slot = SLOT_W'($urandom_range(NUM_SLOTS - 1));
          cpos = CPOS_W'($urandom_range(SLOT_LEN - 1));
          last = 1'($urandom_range(1));
          for (int j = 0; j < cpos; j++)
            if (!pat_written[slot][j]) last = 1'b0;
          send_beat(mpsd_pkg::CMD_LOAD, slot, cpos, SYM_W'($urandom), last);
        end
        2: send_filler(CMD_UNUSED);
        3: send_filler(mpsd_pkg::CMD_RESTART);
        default: begin
          sym = ($urandom_range(4) == 0) ? SYM_W'($urandom) : alpha[$urandom_range(3)];
          send_text(sym);
        end
      endcase
    end
  endtask

  // Random episodes in three stall phases: sender light / receiver heavy,
  // the reverse, then no stalls at all.
  task automatic test_random_traffic();
    int goal;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       begin snd_idle_pct = 16; rcv_idle_pct = 74; end
        1:       begin snd_idle_pct = 74; rcv_idle_pct = 16; end
        default: begin snd_idle_pct = 0;  rcv_idle_pct = 0;  end
      endcase
      goal = beat_count + RAND_BEATS / 3;
      while (beat_count < goal) run_episode();
    end
  endtask

  // Receiver: stall at random per the current phase.
  always @(posedge clk) out_tready <= ($urandom_range(99) >= rcv_idle_pct);

  // Compare every accepted result beat with the oldest expectation.
  always @(posedge clk) begin : check_results
    match_rpt_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result beat: out_tdata %h", out_tdata);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        if (out_tdata[0] !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_tdata[0]);
          mismatches++;
        end
        if (out_tdata[16:1] !== want.pos) begin
          $error("match_position: expected %0d, got %0d", want.pos, out_tdata[16:1]);
          mismatches++;
        end
        if (out_tdata[17] !== want.found_now) begin
          $error("found_now: expected %0d, got %0d", want.found_now, out_tdata[17]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_active_slot_count();
    test_random_traffic();
    wait_idle();
    if (mismatches == 0 && expected_q.size() == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/mpsd_pkg.sv
hw/rtl/mpsd_ram.sv
hw/rtl/mpsd_cell.sv
hw/rtl/multi_pattern_subsequence_detector_core.sv
hw/rtl/mpsd_checker.sv
tb/sv/tb_top.sv
